@@ rtl/core/tftpdf_pkg.sv @@
// ----------------------------------------------------------------------------
// tftpdf_pkg
// Opcodes, result kinds and header sizes for the packet deframer.
// ----------------------------------------------------------------------------
package tftpdf_pkg;

	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;
	localparam logic [15:0] OP_BCAST = 16'd9;

	// byte position of the header fields, counted from one
	localparam logic [16:0] POS_OP_LO   = 17'd2;
	localparam logic [16:0] POS_F1_HI   = 17'd3;
	localparam logic [16:0] POS_F1_LO   = 17'd4;
	localparam logic [16:0] POS_BLK_HI  = 17'd5;
	localparam logic [16:0] DATA_HDR_LEN = 17'd6;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_ERROR   = 3'd2,
		KIND_BCAST   = 3'd3,
		KIND_UNKNOWN = 3'd4
	} kind_t;

endpackage

@@ rtl/core/tftp_style_packet_deframer_top.sv @@
// ----------------------------------------------------------------------------
// tftp_style_packet_deframer_top
// Byte-wide deframer for big-endian TFTP-style packets (DATA, ACK, ERROR,
// BCAST), one result item per body byte or packet end.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, rx_byte): one received byte per item.
//  - Output channel (out_valid/out_ready): one result item carrying the
//    packet kind, the captured header fields, an optional body byte and a
//    last_of_packet mark. Header bytes give no result; an ACK, an empty
//    DATA packet, a string terminator or an unknown opcode gives one result
//    with last_of_packet set.
//  - Throughput: one byte per cycle unless a result waits on out_ready, set
//    by the single decode stage between the input and result registers.
//  - Path: an accepted byte is held in the input register, and its result
//    is then registered in the result register that drives out_valid.
//  - Stall: while a result waits on out_ready the pipeline holds; one more
//    byte is taken into the input register, then in_ready drops.
//  - Reset: arst_n clears the byte counter and all captured fields, so the
//    next byte is taken as the high opcode byte of a new packet.
// ----------------------------------------------------------------------------
module tftp_style_packet_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  packet_kind,
	output logic [15:0] block_number,
	output logic [15:0] data_size,
	output logic [15:0] error_code,
	output logic [7:0]  bcast_flag,
	output logic [7:0]  body_byte,
	output logic        body_valid,
	output logic        last_of_packet
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// deframer state
	logic [16:0] count_q;
	logic [15:0] opcode_q;
	logic [15:0] length_q;
	logic [15:0] block_q;
	logic [15:0] ecode_q;
	logic [7:0]  flag_q;

	logic [16:0] count_n;
	logic [15:0] opcode_n;
	logic [15:0] length_n;
	logic [15:0] block_n;
	logic [15:0] ecode_n;
	logic [7:0]  flag_n;

	// result of the decode stage
	logic                emit;
	tftpdf_pkg::kind_t   kind_c;
	logic [15:0]         blk_c;
	logic [15:0]         size_c;
	logic [15:0]         ecode_c;
	logic [7:0]          flag_c;
	logic [7:0]          body_c;
	logic                bvalid_c;
	logic                last_c;

	logic        advance;
	logic [16:0] cnt;
	logic [15:0] op_full;
	logic        clear;

	tftpdf_pkg::kind_t kind_q;

	// the stage moves whenever the result register is free or being drained
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign cnt     = count_q + 17'd1;
	assign op_full = opcode_q | {8'h00, byte_s1};

	always_comb begin
		count_n  = cnt;
		opcode_n = opcode_q;
		length_n = length_q;
		block_n  = block_q;
		ecode_n  = ecode_q;
		flag_n   = flag_q;
		clear    = 1'b0;
		emit     = 1'b0;
		kind_c   = tftpdf_pkg::KIND_UNKNOWN;
		blk_c    = '0;
		size_c   = '0;
		ecode_c  = '0;
		flag_c   = '0;
		body_c   = '0;
		bvalid_c = 1'b0;
		last_c   = 1'b0;

		priority if (cnt <= 17'd1) begin
			// first byte of a packet, also where the counter wraps
			count_n  = 17'd1;
			opcode_n = {byte_s1, 8'h00};
		end else if (cnt == tftpdf_pkg::POS_OP_LO) begin
			opcode_n = op_full;
			if (op_full != tftpdf_pkg::OP_DATA && op_full != tftpdf_pkg::OP_ACK &&
			    op_full != tftpdf_pkg::OP_ERROR && op_full != tftpdf_pkg::OP_BCAST) begin
				emit   = 1'b1;
				kind_c = tftpdf_pkg::KIND_UNKNOWN;
				last_c = 1'b1;
				clear  = 1'b1;
			end
		end else if (opcode_q == tftpdf_pkg::OP_DATA) begin
			kind_c = tftpdf_pkg::KIND_DATA;
			priority if (cnt == tftpdf_pkg::POS_F1_HI) begin
				length_n = {byte_s1, 8'h00};
			end else if (cnt == tftpdf_pkg::POS_F1_LO) begin
				length_n = length_q | {8'h00, byte_s1};
			end else if (cnt == tftpdf_pkg::POS_BLK_HI) begin
				block_n = {byte_s1, 8'h00};
			end else if (cnt == tftpdf_pkg::DATA_HDR_LEN) begin
				block_n = block_q | {8'h00, byte_s1};
				if (length_q == 16'd0) begin
					emit   = 1'b1;
					blk_c  = block_q | {8'h00, byte_s1};
					last_c = 1'b1;
					clear  = 1'b1;
				end
			end else begin
				emit     = 1'b1;
				blk_c    = block_q;
				size_c   = length_q;
				body_c   = byte_s1;
				bvalid_c = 1'b1;
				last_c   = (cnt == ({1'b0, length_q} + tftpdf_pkg::DATA_HDR_LEN));
				clear    = last_c;
			end
		end else if (opcode_q == tftpdf_pkg::OP_ACK) begin
			kind_c = tftpdf_pkg::KIND_ACK;
			if (cnt == tftpdf_pkg::POS_F1_HI) begin
				block_n = {byte_s1, 8'h00};
			end else begin
				emit   = 1'b1;
				blk_c  = block_q | {8'h00, byte_s1};
				last_c = 1'b1;
				clear  = 1'b1;
			end
		end else if (opcode_q == tftpdf_pkg::OP_ERROR) begin
			kind_c = tftpdf_pkg::KIND_ERROR;
			priority if (cnt == tftpdf_pkg::POS_F1_HI) begin
				ecode_n = {byte_s1, 8'h00};
			end else if (cnt == tftpdf_pkg::POS_F1_LO) begin
				ecode_n = ecode_q | {8'h00, byte_s1};
			end else begin
				emit     = 1'b1;
				ecode_c  = ecode_q;
				body_c   = byte_s1;
				bvalid_c = (byte_s1 != 8'h00);
				last_c   = (byte_s1 == 8'h00);
				clear    = last_c;
			end
		end else begin
			// any other opcode that got past the check is broadcast
			kind_c = tftpdf_pkg::KIND_BCAST;
			if (cnt == tftpdf_pkg::POS_F1_HI) begin
				flag_n = byte_s1;
			end else begin
				emit     = 1'b1;
				flag_c   = flag_q;
				body_c   = byte_s1;
				bvalid_c = (byte_s1 != 8'h00);
				last_c   = (byte_s1 == 8'h00);
				clear    = last_c;
			end
		end

		if (clear) begin
			count_n  = '0;
			opcode_n = '0;
			length_n = '0;
			block_n  = '0;
			ecode_n  = '0;
			flag_n   = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			opcode_q <= '0;
			length_q <= '0;
			block_q  <= '0;
			ecode_q  <= '0;
			flag_q   <= '0;
		end else if (advance && valid_s1) begin
			count_q  <= count_n;
			opcode_q <= opcode_n;
			length_q <= length_n;
			block_q  <= block_n;
			ecode_q  <= ecode_n;
			flag_q   <= flag_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			kind_q         <= kind_c;
			block_number   <= blk_c;
			data_size      <= size_c;
			error_code     <= ecode_c;
			bcast_flag     <= flag_c;
			body_byte      <= bvalid_c ? body_c : 8'h00;
			body_valid     <= bvalid_c;
			last_of_packet <= last_c;
		end
	end

	assign packet_kind = kind_q;

endmodule
